>>> hdl/sogi_pkg.sv
// Shared types, codes and the microcode table of the SOGI PLL sequencer.
package sogi_pkg;

    // Shared multiplier and accumulator widths
    localparam int OPW   = 33;
    localparam int PRODW = 2 * OPW;
    localparam int ACCW  = 50;

    // Sequencer
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = '1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_OSG_GAIN_B0  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OSG_POLE_A1  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OSG_POLE_A2  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OSG_QUAD_B0  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_B0      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_B1      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_FREQ = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 4'd7;

    localparam logic [30:0] NOMINAL_FREQ_RST = 31'd3276800;
    localparam logic [31:0] SAMPLE_PER_RST   = 32'd214748;

    // 0.05 pu in Q2.29
    localparam logic signed [31:0] LOW_Q_LIMIT = 32'sd26843546;

    // Multiplier operand A selects
    localparam logic [3:0] A_B0   = 4'd0;
    localparam logic [3:0] A_A1   = 4'd1;
    localparam logic [3:0] A_A2   = 4'd2;
    localparam logic [3:0] A_QB0  = 4'd3;
    localparam logic [3:0] A_LB0  = 4'd4;
    localparam logic [3:0] A_LB1  = 4'd5;
    localparam logic [3:0] A_NOM  = 4'd6;
    localparam logic [3:0] A_PER  = 4'd7;
    localparam logic [3:0] A_K172 = 4'd8;
    localparam logic [3:0] A_ONE  = 4'd9;
    localparam logic [3:0] A_COS  = 4'd10;
    localparam logic [3:0] A_SIN  = 4'd11;
    localparam logic [3:0] A_HB   = 4'd12;
    localparam logic [3:0] A_TX   = 4'd13;

    // Multiplier operand B selects
    localparam logic [4:0] B_XDIFF = 5'd0;
    localparam logic [4:0] B_XSUM  = 5'd1;
    localparam logic [4:0] B_IH0   = 5'd2;
    localparam logic [4:0] B_IH1   = 5'd3;
    localparam logic [4:0] B_QH0   = 5'd4;
    localparam logic [4:0] B_QH1   = 5'd5;
    localparam logic [4:0] B_IP    = 5'd6;
    localparam logic [4:0] B_QD    = 5'd7;
    localparam logic [4:0] B_QV    = 5'd8;
    localparam logic [4:0] B_PQ    = 5'd9;
    localparam logic [4:0] B_INTEG = 5'd10;
    localparam logic [4:0] B_F32   = 5'd11;
    localparam logic [4:0] B_PHASE = 5'd12;
    localparam logic [4:0] B_ONE   = 5'd13;
    localparam logic [4:0] B_X2    = 5'd14;
    localparam logic [4:0] B_TX    = 5'd15;

    // Product scaling (arithmetic right shift)
    localparam logic [2:0] SH_0  = 3'd0;
    localparam logic [2:0] SH_14 = 3'd1;
    localparam logic [2:0] SH_16 = 3'd2;
    localparam logic [2:0] SH_29 = 3'd3;
    localparam logic [2:0] SH_30 = 3'd4;
    localparam logic [2:0] SH_34 = 3'd5;

    // Accumulator base
    localparam logic [1:0] BASE_ZERO = 2'd0;
    localparam logic [1:0] BASE_ACC  = 2'd1;
    localparam logic [1:0] BASE_K    = 2'd2;

    // Constant base selects
    localparam logic [2:0] K_C0   = 3'd0;
    localparam logic [2:0] K_C1   = 3'd1;
    localparam logic [2:0] K_C2   = 3'd2;
    localparam logic [2:0] K_C3   = 3'd3;
    localparam logic [2:0] K_HALF = 3'd4;

    // Writeback targets
    localparam logic [3:0] WB_NONE  = 4'd0;
    localparam logic [3:0] WB_IP    = 4'd1;
    localparam logic [3:0] WB_QD    = 4'd2;
    localparam logic [3:0] WB_QV    = 4'd3;
    localparam logic [3:0] WB_DV    = 4'd4;
    localparam logic [3:0] WB_INTEG = 4'd5;
    localparam logic [3:0] WB_F32   = 4'd6;
    localparam logic [3:0] WB_PHASE = 4'd7;
    localparam logic [3:0] WB_X2    = 4'd8;
    localparam logic [3:0] WB_HB    = 4'd9;
    localparam logic [3:0] WB_TRIG  = 4'd10;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [4:0] b_sel;
        logic [2:0] sh;
        logic [1:0] base;
        logic       neg;
        logic [2:0] k_sel;
        logic [3:0] wb;
        logic       trig_cos;
    } uop_t;

    typedef struct packed {
        logic [3:0]      wb;
        logic            trig_cos;
        logic [ACCW-1:0] acc;
        logic [31:0]     sat;
    } alu_res_t;

    typedef struct packed {
        logic              accept;
        logic              finish;
        logic              busy;
        logic [STEP_W-1:0] step;
    } seq_stat_t;

    localparam uop_t UOP_NOP = '{
        a_sel: A_ONE, b_sel: B_ONE, sh: SH_0, base: BASE_ACC, neg: 1'b0,
        k_sel: K_C0, wb: WB_NONE, trig_cos: 1'b0
    };

    function automatic uop_t mk_uop(
        input logic [3:0] a,
        input logic [4:0] b,
        input logic [2:0] sh,
        input logic [1:0] base,
        input logic       neg,
        input logic [2:0] k,
        input logic [3:0] wb,
        input logic       tc
    );
        uop_t u;
        u.a_sel    = a;
        u.b_sel    = b;
        u.sh       = sh;
        u.base     = base;
        u.neg      = neg;
        u.k_sel    = k;
        u.wb       = wb;
        u.trig_cos = tc;
        return u;
    endfunction

    // One multiply issued per step; its result retires in the next step.
    // Sine and cosine polynomial chains interleave to hide the retire delay.
    function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
        uop_t u;
        unique case (step)
            // in-phase biquad
            5'd0:  u = mk_uop(A_B0,   B_XDIFF, SH_14, BASE_ZERO, 1'b0, K_C0, WB_NONE,  1'b0);
            5'd1:  u = mk_uop(A_A1,   B_IH0,   SH_29, BASE_ACC,  1'b0, K_C0, WB_NONE,  1'b0);
            5'd2:  u = mk_uop(A_A2,   B_IH1,   SH_29, BASE_ACC,  1'b0, K_C0, WB_IP,    1'b0);
            // quadrature biquad
            5'd3:  u = mk_uop(A_QB0,  B_XSUM,  SH_14, BASE_ZERO, 1'b0, K_C0, WB_NONE,  1'b0);
            5'd4:  u = mk_uop(A_A1,   B_QH0,   SH_29, BASE_ACC,  1'b0, K_C0, WB_NONE,  1'b0);
            5'd5:  u = mk_uop(A_A2,   B_QH1,   SH_29, BASE_ACC,  1'b0, K_C0, WB_QD,    1'b0);
            // Park rotation
            5'd6:  u = mk_uop(A_COS,  B_IP,    SH_14, BASE_ZERO, 1'b0, K_C0, WB_NONE,  1'b0);
            5'd7:  u = mk_uop(A_SIN,  B_QD,    SH_14, BASE_ACC,  1'b0, K_C0, WB_QV,    1'b0);
            5'd8:  u = mk_uop(A_COS,  B_QD,    SH_14, BASE_ZERO, 1'b0, K_C0, WB_NONE,  1'b0);
            5'd9:  u = mk_uop(A_SIN,  B_IP,    SH_14, BASE_ACC,  1'b1, K_C0, WB_DV,    1'b0);
            // loop filter
            5'd10: u = mk_uop(A_ONE,  B_INTEG, SH_0,  BASE_ZERO, 1'b0, K_C0, WB_NONE,  1'b0);
            5'd11: u = mk_uop(A_LB0,  B_QV,    SH_34, BASE_ACC,  1'b0, K_C0, WB_NONE,  1'b0);
            5'd12: u = mk_uop(A_LB1,  B_PQ,    SH_34, BASE_ACC,  1'b0, K_C0, WB_INTEG, 1'b0);
            // frequency and phase
            5'd13: u = mk_uop(A_NOM,  B_ONE,   SH_0,  BASE_ZERO, 1'b0, K_C0, WB_NONE,  1'b0);
            5'd14: u = mk_uop(A_ONE,  B_INTEG, SH_0,  BASE_ACC,  1'b0, K_C0, WB_F32,   1'b0);
            5'd15: u = mk_uop(A_ONE,  B_PHASE, SH_0,  BASE_ZERO, 1'b0, K_C0, WB_NONE,  1'b0);
            5'd16: u = mk_uop(A_PER,  B_F32,   SH_16, BASE_ACC,  1'b0, K_C0, WB_PHASE, 1'b0);
            // quarter-wave polynomial, sine then cosine in each pair
            5'd18: u = mk_uop(A_TX,   B_TX,    SH_30, BASE_ZERO, 1'b0, K_C0, WB_X2,    1'b0);
            5'd19: u = mk_uop(A_TX,   B_TX,    SH_30, BASE_ZERO, 1'b0, K_C0, WB_X2,    1'b1);
            5'd20: u = mk_uop(A_K172, B_X2,    SH_30, BASE_K,    1'b1, K_C0, WB_HB,    1'b0);
            5'd21: u = mk_uop(A_K172, B_X2,    SH_30, BASE_K,    1'b1, K_C0, WB_HB,    1'b1);
            5'd22: u = mk_uop(A_HB,   B_X2,    SH_30, BASE_K,    1'b1, K_C1, WB_HB,    1'b0);
            5'd23: u = mk_uop(A_HB,   B_X2,    SH_30, BASE_K,    1'b1, K_C1, WB_HB,    1'b1);
            5'd24: u = mk_uop(A_HB,   B_X2,    SH_30, BASE_K,    1'b1, K_C2, WB_HB,    1'b0);
            5'd25: u = mk_uop(A_HB,   B_X2,    SH_30, BASE_K,    1'b1, K_C2, WB_HB,    1'b1);
            5'd26: u = mk_uop(A_HB,   B_X2,    SH_30, BASE_K,    1'b1, K_C3, WB_HB,    1'b0);
            5'd27: u = mk_uop(A_HB,   B_X2,    SH_30, BASE_K,    1'b1, K_C3, WB_HB,    1'b1);
            5'd28: u = mk_uop(A_HB,   B_TX,    SH_30, BASE_K,    1'b0, K_HALF, WB_TRIG, 1'b0);
            5'd29: u = mk_uop(A_HB,   B_TX,    SH_30, BASE_K,    1'b0, K_HALF, WB_TRIG, 1'b1);
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

>>> hdl/sogi_alu.sv
// Shared 33x33 multiplier with scaling shift, accumulator and 32-bit saturation.
module sogi_alu import sogi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic signed [OPW-1:0]  op_a,
    input  logic signed [OPW-1:0]  op_b,
    input  uop_t                   uop,
    output alu_res_t               res
);

    logic signed [PRODW-1:0] prod_reg;
    uop_t                    rop_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic signed [ACCW-1:0]  acc_next;
    logic signed [PRODW-1:0] shifted;
    logic signed [ACCW-1:0]  term;
    logic signed [ACCW-1:0]  base;
    logic [ACCW-32:0]        hi;

    function automatic logic signed [ACCW-1:0] k_value(input logic [2:0] k);
        logic signed [ACCW-1:0] v;
        case (k)
            K_C0:    v = ACCW'(5026995);
            K_C1:    v = ACCW'(85569306);
            K_C2:    v = ACCW'(693598668);
            K_C3:    v = ACCW'(1686629713);
            K_HALF:  v = ACCW'(32768);
            default: v = '0;
        endcase
        return v;
    endfunction

    // control follows the product into the retire stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rop_reg <= UOP_NOP;
        end
        else
        begin
            rop_reg <= uop;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        case (rop_reg.sh)
            SH_14:   shifted = prod_reg >>> 14;
            SH_16:   shifted = prod_reg >>> 16;
            SH_29:   shifted = prod_reg >>> 29;
            SH_30:   shifted = prod_reg >>> 30;
            SH_34:   shifted = prod_reg >>> 34;
            default: shifted = prod_reg;
        endcase
        term = shifted[ACCW-1:0];

        case (rop_reg.base)
            BASE_ACC: base = acc_reg;
            BASE_K:   base = k_value(rop_reg.k_sel);
            default:  base = '0;
        endcase

        acc_next = rop_reg.neg ? (base - term) : (base + term);
        hi       = acc_next[ACCW-1:31];
    end

    assign res.wb       = rop_reg.wb;
    assign res.trig_cos = rop_reg.trig_cos;
    assign res.acc      = acc_next;
    assign res.sat      = ((&hi) || !(|hi)) ? acc_next[31:0]
                        : (acc_next[ACCW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

endmodule

>>> hdl/sogi_seq.sv
// Step sequencer: input handshake, step counter and microcode fetch.
module sogi_seq import sogi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_free,
    output logic      in_stall,
    output uop_t      uop,
    output seq_stat_t stat
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              finish;
    logic              accept;

    // last step holds until the output register can take the item
    assign finish   = busy_reg && (step_reg == LAST_STEP) && out_free;
    assign in_stall = busy_reg && !finish;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && (step_reg != LAST_STEP))
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign uop         = busy_reg ? uop_rom(step_reg) : UOP_NOP;
    assign stat.accept = accept;
    assign stat.finish = finish;
    assign stat.busy   = busy_reg;
    assign stat.step   = step_reg;

endmodule

>>> hdl/sogi_single_phase_pll.sv
// SOGI single-phase PLL top: registers, operand routing, state and output register.
// Throughput: one item at a time; the next item is accepted as the last one finishes,
//   and the last step holds while the output register is full. Every step issues one
//   product on the single shared 33x33 multiplier: 29 products and three empty slots.
// Reset: all loop state clears to zero, nominal_freq to 50 Hz, sample_period to 1/20000 s;
//   no clearing pass, the block takes items as soon as reset is released.
module sogi_single_phase_pll import sogi_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [15:0]   grid_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   sine_out,
    output logic signed [15:0]   cosine_out,
    output logic [31:0]          phase_out,
    output logic signed [31:0]   freq_out,
    output logic signed [31:0]   q_level,
    output logic signed [31:0]   d_level,
    output logic                 low_q_flag
);

    localparam int QB = SINE_ADDR_BITS - 2;

    // configuration
    logic signed [31:0] osg_gain_b0_reg;
    logic signed [31:0] osg_pole_a1_reg;
    logic signed [31:0] osg_pole_a2_reg;
    logic signed [31:0] osg_quad_b0_reg;
    logic signed [31:0] loop_b0_reg;
    logic signed [31:0] loop_b1_reg;
    logic [30:0]        nominal_freq_reg;
    logic [31:0]        sample_period_reg;

    // loop state
    logic signed [15:0] samp0_reg;
    logic signed [15:0] samp1_reg;
    logic signed [31:0] ih0_reg;
    logic signed [31:0] ih1_reg;
    logic signed [31:0] qh0_reg;
    logic signed [31:0] qh1_reg;
    logic signed [31:0] prev_q_reg;
    logic signed [31:0] loop_integral_reg;
    logic [31:0]        phase_acc_reg;
    logic signed [15:0] last_sine_reg;
    logic signed [15:0] last_cosine_reg;

    // per-item scratch
    logic signed [15:0] x0_reg;
    logic signed [31:0] ip_reg;
    logic signed [31:0] qd_reg;
    logic signed [31:0] qv_reg;
    logic signed [31:0] dv_reg;
    logic signed [31:0] f32_reg;
    logic [30:0]        x2s_reg;
    logic [30:0]        x2c_reg;
    logic [31:0]        hbs_reg;
    logic [31:0]        hbc_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] sine_reg;
    logic signed [15:0] cosine_reg;
    logic [31:0]        phase_reg;
    logic signed [31:0] freq_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] d_reg;
    logic               low_q_reg;

    logic               out_free;
    uop_t               uop;
    seq_stat_t          stat;
    alu_res_t           res;
    logic signed [OPW-1:0] op_a;
    logic signed [OPW-1:0] op_b;

    logic signed [16:0] xdiff;
    logic signed [17:0] xsum;

    logic [SINE_ADDR_BITS-1:0] addr_s;
    logic [SINE_ADDR_BITS-1:0] addr_c;
    logic [30:0]        xr_s;
    logic [30:0]        xr_c;
    logic [30:0]        tx_s;
    logic [30:0]        tx_c;
    logic [30:0]        tx_issue;
    logic [15:0]        trig_mag;
    logic [15:0]        trig_clip;
    logic               trig_neg;
    logic signed [15:0] trig_val;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    sogi_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_stall (in_stall),
        .uop      (uop),
        .stat     (stat)
    );

    sogi_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .op_a  (op_a),
        .op_b  (op_b),
        .uop   (uop),
        .res   (res)
    );

    // biquad input taps
    assign xdiff = {x0_reg[15], x0_reg} - {samp1_reg[15], samp1_reg};
    assign xsum  = {{2{x0_reg[15]}}, x0_reg} + {samp0_reg[15], samp0_reg, 1'b0}
                 + {{2{samp1_reg[15]}}, samp1_reg};

    // fold the table address into a quarter-wave angle in Q1.30
    assign addr_s = phase_acc_reg[31 -: SINE_ADDR_BITS];
    assign addr_c = addr_s + {2'b01, {QB{1'b0}}};
    assign xr_s   = {1'b0, addr_s[QB-1:0], {(32 - SINE_ADDR_BITS){1'b0}}};
    assign xr_c   = {1'b0, addr_c[QB-1:0], {(32 - SINE_ADDR_BITS){1'b0}}};
    assign tx_s   = addr_s[QB] ? (31'h4000_0000 - xr_s) : xr_s;
    assign tx_c   = addr_c[QB] ? (31'h4000_0000 - xr_c) : xr_c;
    assign tx_issue = uop.trig_cos ? tx_c : tx_s;

    always_comb
    begin
        case (uop.a_sel)
            A_B0:    op_a = {osg_gain_b0_reg[31], osg_gain_b0_reg};
            A_A1:    op_a = {osg_pole_a1_reg[31], osg_pole_a1_reg};
            A_A2:    op_a = {osg_pole_a2_reg[31], osg_pole_a2_reg};
            A_QB0:   op_a = {osg_quad_b0_reg[31], osg_quad_b0_reg};
            A_LB0:   op_a = {loop_b0_reg[31], loop_b0_reg};
            A_LB1:   op_a = {loop_b1_reg[31], loop_b1_reg};
            A_NOM:   op_a = {2'b00, nominal_freq_reg};
            A_PER:   op_a = {1'b0, sample_period_reg};
            A_K172:  op_a = 33'sd172272;
            A_COS:   op_a = {{(OPW - 16){last_cosine_reg[15]}}, last_cosine_reg};
            A_SIN:   op_a = {{(OPW - 16){last_sine_reg[15]}}, last_sine_reg};
            A_HB:    op_a = {1'b0, (uop.trig_cos ? hbc_reg : hbs_reg)};
            A_TX:    op_a = {2'b00, tx_issue};
            default: op_a = 33'sd1;
        endcase

        case (uop.b_sel)
            B_XDIFF: op_b = {{(OPW - 17){xdiff[16]}}, xdiff};
            B_XSUM:  op_b = {{(OPW - 18){xsum[17]}}, xsum};
            B_IH0:   op_b = {ih0_reg[31], ih0_reg};
            B_IH1:   op_b = {ih1_reg[31], ih1_reg};
            B_QH0:   op_b = {qh0_reg[31], qh0_reg};
            B_QH1:   op_b = {qh1_reg[31], qh1_reg};
            B_IP:    op_b = {ip_reg[31], ip_reg};
            B_QD:    op_b = {qd_reg[31], qd_reg};
            B_QV:    op_b = {qv_reg[31], qv_reg};
            B_PQ:    op_b = {prev_q_reg[31], prev_q_reg};
            B_INTEG: op_b = {loop_integral_reg[31], loop_integral_reg};
            B_F32:   op_b = {f32_reg[31], f32_reg};
            B_PHASE: op_b = {1'b0, phase_acc_reg};
            B_X2:    op_b = {2'b00, (uop.trig_cos ? x2c_reg : x2s_reg)};
            B_TX:    op_b = {2'b00, tx_issue};
            default: op_b = 33'sd1;
        endcase
    end

    // round the polynomial to Q1.14, clamp at one and apply the half-turn sign
    assign trig_mag  = res.acc[31:16];
    assign trig_clip = (trig_mag > 16'd16384) ? 16'd16384 : trig_mag;
    assign trig_neg  = res.trig_cos ? addr_c[QB+1] : addr_s[QB+1];
    assign trig_val  = trig_neg ? -$signed(trig_clip) : $signed(trig_clip);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osg_gain_b0_reg   <= '0;
            osg_pole_a1_reg   <= '0;
            osg_pole_a2_reg   <= '0;
            osg_quad_b0_reg   <= '0;
            loop_b0_reg       <= '0;
            loop_b1_reg       <= '0;
            nominal_freq_reg  <= NOMINAL_FREQ_RST;
            sample_period_reg <= SAMPLE_PER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OSG_GAIN_B0:  osg_gain_b0_reg   <= cfg_data;
                REG_OSG_POLE_A1:  osg_pole_a1_reg   <= cfg_data;
                REG_OSG_POLE_A2:  osg_pole_a2_reg   <= cfg_data;
                REG_OSG_QUAD_B0:  osg_quad_b0_reg   <= cfg_data;
                REG_LOOP_B0:      loop_b0_reg       <= cfg_data;
                REG_LOOP_B1:      loop_b1_reg       <= cfg_data;
                REG_NOMINAL_FREQ: nominal_freq_reg  <= cfg_data[30:0];
                REG_SAMPLE_PER:   sample_period_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // loop state: written back by the unit or committed when the item finishes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp0_reg         <= '0;
            samp1_reg         <= '0;
            ih0_reg           <= '0;
            ih1_reg           <= '0;
            qh0_reg           <= '0;
            qh1_reg           <= '0;
            prev_q_reg        <= '0;
            loop_integral_reg <= '0;
            phase_acc_reg     <= '0;
            last_sine_reg     <= '0;
            last_cosine_reg   <= '0;
        end
        else
        begin
            if (res.wb == WB_INTEG)
            begin
                loop_integral_reg <= res.sat;
            end
            if (res.wb == WB_PHASE)
            begin
                phase_acc_reg <= res.acc[31:0];
            end
            if (res.wb == WB_TRIG)
            begin
                if (res.trig_cos)
                begin
                    last_cosine_reg <= trig_val;
                end
                else
                begin
                    last_sine_reg <= trig_val;
                end
            end
            if (stat.finish)
            begin
                samp1_reg  <= samp0_reg;
                samp0_reg  <= x0_reg;
                ih1_reg    <= ih0_reg;
                ih0_reg    <= ip_reg;
                qh1_reg    <= qh0_reg;
                qh0_reg    <= qd_reg;
                prev_q_reg <= qv_reg;
            end
        end
    end

    // per-item scratch
    always_ff @(posedge clk)
    begin
        if (stat.accept)
        begin
            x0_reg <= grid_sample;
        end
        case (res.wb)
            WB_IP:  ip_reg  <= res.sat;
            WB_QD:  qd_reg  <= res.sat;
            WB_QV:  qv_reg  <= res.sat;
            WB_DV:  dv_reg  <= res.sat;
            WB_F32: f32_reg <= res.sat;
            WB_X2:
            begin
                if (res.trig_cos)
                begin
                    x2c_reg <= res.acc[30:0];
                end
                else
                begin
                    x2s_reg <= res.acc[30:0];
                end
            end
            WB_HB:
            begin
                if (res.trig_cos)
                begin
                    hbc_reg <= res.acc[31:0];
                end
                else
                begin
                    hbs_reg <= res.acc[31:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.finish)
        begin
            sine_reg   <= last_sine_reg;
            cosine_reg <= last_cosine_reg;
            phase_reg  <= phase_acc_reg;
            freq_reg   <= f32_reg;
            q_reg      <= qv_reg;
            d_reg      <= dv_reg;
            low_q_reg  <= (qv_reg < LOW_Q_LIMIT);
        end
    end

    assign out_valid  = out_valid_reg;
    assign sine_out   = sine_reg;
    assign cosine_out = cosine_reg;
    assign phase_out  = phase_reg;
    assign freq_out   = freq_reg;
    assign q_level    = q_reg;
    assign d_level    = d_reg;
    assign low_q_flag = low_q_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        stat.accept |=> (stat.busy && (stat.step == '0)))
        else $error("accepted item did not start at the first step");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        stat.finish |=> out_valid)
        else $error("finished item not presented at the output");

    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_sine_reg >= -16'sd16384) && (last_sine_reg <= 16'sd16384)
        && (last_cosine_reg >= -16'sd16384) && (last_cosine_reg <= 16'sd16384))
        else $error("sine or cosine beyond one per unit");

endmodule
